@@ hw/rtl/rita_pkg.sv @@
// Shared types, constants and helpers for the radix integer-to-ASCII converter.
`timescale 1ns / 1ps
`default_nettype none

package rita_pkg;

    localparam int VALUE_W        = 32;
    localparam int VALUE_BITS_DEF = 32;
    localparam int RADIX_W        = 5;
    localparam int DIGIT_W        = 5;
    localparam int CHAR_W         = 8;
    localparam int DIV_BITS       = 4;

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd26;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;

    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_A    = 8'h41;
    localparam logic [CHAR_W-1:0] DIGIT_TEN = 8'd10;

    typedef struct packed {
        logic load;     // take a new value, clear counters
        logic div;      // DIV_BITS shift-subtract steps of the digit division
        logic put;      // store the remainder as the next digit
        logic rd_next;  // step the read position towards the least significant digit
        logic out_load; // capture a character into the output register
        logic out_err;  // capture the bad-radix result
    } t_cmd;

    typedef struct packed {
        logic radix_ok;
        logic step_last;
        logic more;
        logic rd_last;
    } t_sts;

    function automatic logic [CHAR_W-1:0] to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] w;
        w = {{(CHAR_W-DIGIT_W){1'b0}}, d};
        if (d > DIGIT_W'(9)) begin
            return CHAR_W'(CHAR_A + w - DIGIT_TEN);
        end
        return CHAR_W'(CHAR_ZERO + w);
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/rita_in_if.sv @@
// Input channel: one value per beat.
`timescale 1ns / 1ps
`default_nettype none

interface rita_in_if;
    logic                            valid;
    logic                            ready;
    logic [rita_pkg::VALUE_W-1:0]    value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/rita_out_if.sv @@
// Output channel: one character per beat.
`timescale 1ns / 1ps
`default_nettype none

interface rita_out_if;
    logic                          valid;
    logic                          ready;
    logic [rita_pkg::CHAR_W-1:0]   digit_char;
    logic                          last_char;
    logic                          bad_radix;

    modport source (output valid, output digit_char, output last_char, output bad_radix,
                    input ready);
    modport sink   (input valid, input digit_char, input last_char, input bad_radix,
                    output ready);
endinterface

`default_nettype wire

@@ hw/rtl/rita_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module rita_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ hw/rtl/rita_datapath.sv @@
// Datapath: radix register, shift-subtract divider, digit store and output register.
`timescale 1ns / 1ps
`default_nettype none

module rita_datapath #(
    parameter int VALUE_BITS = rita_pkg::VALUE_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [rita_pkg::RADIX_W-1:0]      i_cfg_wdata,
    input  wire logic [rita_pkg::VALUE_W-1:0]      i_value,
    input  wire rita_pkg::t_cmd                    i_cmd,
    output      rita_pkg::t_sts                    o_sts,
    output      logic [rita_pkg::CHAR_W-1:0]       o_digit_char,
    output      logic                              o_last_char,
    output      logic                              o_bad_radix
);

    localparam int DB    = rita_pkg::DIV_BITS;
    localparam int QW    = ((VALUE_BITS + DB - 1) / DB) * DB;
    localparam int NSTEP = QW / DB;
    localparam int SW    = (NSTEP > 1) ? $clog2(NSTEP) : 1;
    localparam int AW    = $clog2(VALUE_BITS);
    localparam int CW    = $clog2(VALUE_BITS + 1);
    localparam int TAKE  = (VALUE_BITS < rita_pkg::VALUE_W) ? VALUE_BITS : rita_pkg::VALUE_W;
    localparam int RW    = rita_pkg::RADIX_W;

    logic [RW-1:0]                 r_radix;
    logic [QW-1:0]                 r_quot, n_quot;
    logic [RW-1:0]                 r_rem, n_rem;
    logic [SW-1:0]                 r_step;
    logic [CW-1:0]                 r_count;
    logic [CW-1:0]                 r_rd;
    logic [rita_pkg::CHAR_W-1:0]   r_char;
    logic                          r_last;
    logic                          r_bad;
    logic [rita_pkg::DIGIT_W-1:0]  w_rdata;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= rita_pkg::RADIX_RESET;
        end else if (i_cfg_we) begin
            r_radix <= i_cfg_wdata;
        end
    end

    // DB restoring-division steps; the remainder never exceeds the radix
    always_comb begin
        logic [RW:0] t;
        logic        qb;
        n_quot = r_quot;
        n_rem  = r_rem;
        for (int b = 0; b < DB; b++) begin
            t = {n_rem, n_quot[QW-1]};
            if (t >= {1'b0, r_radix}) begin
                n_rem = RW'(t - {1'b0, r_radix});
                qb    = 1'b1;
            end else begin
                n_rem = t[RW-1:0];
                qb    = 1'b0;
            end
            n_quot = {n_quot[QW-2:0], qb};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quot  <= '0;
            r_rem   <= '0;
            r_step  <= '0;
            r_count <= '0;
            r_rd    <= '0;
        end else begin
            if (i_cmd.load) begin
                r_quot  <= QW'(i_value[TAKE-1:0]);
                r_rem   <= '0;
                r_step  <= '0;
                r_count <= '0;
            end else if (i_cmd.div) begin
                r_quot <= n_quot;
                r_rem  <= n_rem;
                r_step <= SW'(r_step + 1'b1);
            end else if (i_cmd.put) begin
                r_rem   <= '0;
                r_step  <= '0;
                r_count <= CW'(r_count + 1'b1);
                r_rd    <= r_count;
            end
            if (i_cmd.rd_next) begin
                r_rd <= CW'(r_rd - 1'b1);
            end
        end
    end

    rita_ram #(
        .WIDTH (rita_pkg::DIGIT_W),
        .DEPTH (VALUE_BITS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.put),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (r_rem),
        .i_raddr (r_rd[AW-1:0]),
        .o_rdata (w_rdata)
    );

    // Output register holds its beat until the controller loads the next one
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_err) begin
            r_char <= '0;
            r_last <= 1'b1;
            r_bad  <= 1'b1;
        end else if (i_cmd.out_load) begin
            r_char <= rita_pkg::to_ascii(w_rdata);
            r_last <= (r_rd == '0);
            r_bad  <= 1'b0;
        end
    end

    assign o_sts.radix_ok  = (r_radix >= rita_pkg::RADIX_MIN) &&
                             (r_radix <= rita_pkg::RADIX_MAX);
    assign o_sts.step_last = (r_step == SW'(NSTEP - 1));
    assign o_sts.more      = (r_quot != '0) &&
                             ({1'b0, r_count} + 1'b1 < (CW + 1)'(VALUE_BITS));
    assign o_sts.rd_last   = (r_rd == '0);

    assign o_digit_char = r_char;
    assign o_last_char  = r_last;
    assign o_bad_radix  = r_bad;

endmodule

`default_nettype wire

@@ hw/rtl/rita_ctrl.sv @@
// Controller: sequences division, digit storage and character output.
`timescale 1ns / 1ps
`default_nettype none

module rita_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output      logic           o_in_ready,
    output      logic           o_out_valid,
    input  wire logic           i_out_ready,
    input  wire rita_pkg::t_sts i_sts,
    output      rita_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_PUT,
        ST_RD,
        ST_LD,
        ST_SEND
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_sts.radix_ok) begin
                        n_state = ST_DIV;
                    end else begin
                        o_cmd.out_err = 1'b1;
                        n_state       = ST_SEND;
                    end
                end
            end
            ST_DIV: begin
                o_cmd.div = 1'b1;
                if (i_sts.step_last) begin
                    n_state = ST_PUT;
                end
            end
            ST_PUT: begin
                o_cmd.put = 1'b1;
                n_state   = i_sts.more ? ST_DIV : ST_RD;
            end
            ST_RD: begin
                n_state = ST_LD;
            end
            ST_LD: begin
                o_cmd.out_load = 1'b1;
                n_state        = ST_SEND;
            end
            ST_SEND: begin
                if (i_out_ready) begin
                    if (i_sts.rd_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        o_cmd.rd_next = 1'b1;
                        n_state       = ST_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = (r_state == ST_SEND);

endmodule

`default_nettype wire

@@ hw/rtl/radix_integer_to_ascii_core.sv @@
// Top level of the radix integer-to-ASCII converter.
// Each digit is found by 4-bit division steps over all VALUE_BITS (rounded up to whole
//   4-bit steps) and then stored; each character beat then goes through store read and output.
// One value at a time: the next value is taken only after its last character is sent, and the
//   rate is set by the 4-bit-per-cycle divider and the single store read port.
// A bad radix offers its single beat the cycle after the value is taken.
// Reset (synchronous, active low) returns the controller to idle and the radix to 10.
`timescale 1ns / 1ps
`default_nettype none

module radix_integer_to_ascii_core #(
    parameter int VALUE_BITS = rita_pkg::VALUE_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [rita_pkg::RADIX_W-1:0]  i_cfg_wdata,
    rita_in_if.sink                            i_in,
    rita_out_if.source                         o_out
);

    // Command and status between the controller and the datapath
    rita_pkg::t_cmd w_cmd;
    rita_pkg::t_sts w_sts;

    // Controller: accepts a beat only when idle, and presents each character as one beat
    rita_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // Datapath: divides by the radix, stores digits least significant first,
    // then reads them back from the most significant end
    rita_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_value      (i_in.value),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .o_digit_char (o_out.digit_char),
        .o_last_char  (o_out.last_char),
        .o_bad_radix  (o_out.bad_radix)
    );

endmodule

`default_nettype wire
